>>> src/rfd_pkg.sv
package rfd_pkg;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_UID   = 3'd1;
    localparam logic [2:0] EV_GOOD  = 3'd2;
    localparam logic [2:0] EV_CHECK = 3'd3;
    localparam logic [2:0] EV_END   = 3'd4;
    localparam logic [2:0] EV_OVER  = 3'd5;

    localparam logic [7:0] UID_LENGTH = 8'd6;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [7:0] START_MARKER_RST = 8'h02;
    localparam logic [7:0] END_MARKER_RST   = 8'h03;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  check;
        logic [7:0]  frame_len;
        logic [7:0]  count;
        logic [31:0] uid;
        logic [7:0]  first;
    } t_parse;

    typedef struct packed {
        logic [2:0]  frame_event;
        logic [5:0]  payload_length;
        logic [7:0]  status_byte;
        logic [31:0] card_uid;
        logic        uid_valid;
    } t_result;

endpackage

>>> src/rfd_step.sv
module rfd_step #(
    parameter int MAX_FRAME = 64
) (
    input  rfd_pkg::t_parse  i_state,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_start_marker,
    input  logic [7:0]       i_end_marker,
    output rfd_pkg::t_parse  o_state,
    output rfd_pkg::t_result o_result
);
    import rfd_pkg::*;

    localparam logic [8:0] MaxFrame = 9'(MAX_FRAME);

    logic [8:0] len_plus;
    logic [7:0] count_inc;

    assign len_plus  = {1'b0, i_byte} + 9'd4;
    assign count_inc = i_state.count + 8'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.frame_event = EV_NONE;
        case (i_state.phase)
            PH_HUNT: begin
                if (i_byte == i_start_marker) begin
                    o_state       = '0;
                    o_state.phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                o_state.check = i_byte;
                o_state.phase = PH_LEN;
            end
            PH_LEN: begin
                o_state.check = i_state.check ^ i_byte;
                if (len_plus > MaxFrame) begin
                    o_result.frame_event = EV_OVER;
                    o_state.phase        = PH_HUNT;
                end else begin
                    o_state.frame_len = i_byte;
                    o_state.count     = '0;
                    o_state.phase     = (i_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                o_state.check = i_state.check ^ i_byte;
                if (i_state.count == 8'd0) begin
                    o_state.first = i_byte;
                end
                if (i_state.count >= 8'd2 && i_state.count <= 8'd5) begin
                    o_state.uid = {i_state.uid[23:0], i_byte};
                end
                o_state.count = count_inc;
                if (count_inc >= i_state.frame_len) begin
                    o_state.phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_state.check = i_state.check ^ i_byte;
                o_state.phase = PH_END;
            end
            default: begin
                if (i_byte != i_end_marker) begin
                    o_result.frame_event = EV_END;
                end else if (i_state.check != 8'd0) begin
                    o_result.frame_event = EV_CHECK;
                end else if (i_state.frame_len == UID_LENGTH) begin
                    o_result.frame_event = EV_UID;
                    o_result.card_uid    = i_state.uid;
                    o_result.uid_valid   = 1'b1;
                end else begin
                    o_result.frame_event = EV_GOOD;
                end
                o_result.payload_length = i_state.frame_len[5:0];
                o_result.status_byte    = i_state.first;
                o_state.phase           = PH_HUNT;
            end
        endcase
    end

endmodule

>>> src/reader_frame_deframer.sv
// A result item is shown in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless output stalls; parse state and result
// registers update together; a held result lets the next byte in when taken.
// Reset (synchronous, active low): hunting for the start byte, markers back
// to 0x02 and 0x03, no result pending.
module reader_frame_deframer #(
    parameter int MAX_FRAME = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_frame_event,
    output logic [5:0]  o_payload_length,
    output logic [7:0]  o_status_byte,
    output logic [31:0] o_card_uid,
    output logic        o_uid_valid
);
    import rfd_pkg::*;

    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    t_parse     r_state;
    t_parse     n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    rfd_step #(
        .MAX_FRAME(MAX_FRAME)
    ) u_step (
        .i_state        (r_state),
        .i_byte         (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_MARKER: r_start_marker <= i_cfg_wdata;
                REG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                default:          r_start_marker <= r_start_marker;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_event    = r_result.frame_event;
    assign o_payload_length = r_result.payload_length;
    assign o_status_byte    = r_result.status_byte;
    assign o_card_uid       = r_result.card_uid;
    assign o_uid_valid      = r_result.uid_valid;

    a_uid_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_uid_valid |-> o_frame_event == EV_UID)
        else $error("uid flagged without uid event");

    a_none_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_event == EV_NONE || o_frame_event == EV_OVER)
        |-> o_payload_length == 6'd0 && o_card_uid == 32'd0 && !o_uid_valid)
        else $error("non-final event carries frame fields");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= PH_END)
        else $error("parse phase out of range");

    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("byte accepted while result stalled");

    a_hunt_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_state.phase == PH_END |=> r_state.phase == PH_HUNT)
        else $error("no return to hunting after end byte");

endmodule
